// ----- hw/rtl/wks_pkg.sv -----
// Shared types and constants for the weighted KS distance block.
`default_nettype none
package wks_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned FRAC_FB  = 16;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0]        weight;
  } req_t;

  typedef struct packed {
    logic [FRAC_W-1:0] distance;
    logic              empty_set;
    logic              overflowed;
  } res_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic init;
    logic adv_j;
    logic div_go;
    logic step_i;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic more_j;
    logic div_done;
    logic last_i;
  } stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wks_div.sv -----
// Iterative restoring divider: q = floor(num * 2^16 / den), num <= den.
`default_nettype none
module wks_div import wks_pkg::*; #(
  parameter int unsigned W = 27
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [W-1:0]      num_i,
  input  wire logic [W-1:0]      den_i,
  output logic [FRAC_W-1:0]      quo_o,
  output logic                   done_o
);

  logic [W:0]          rem_q, rem_d;
  logic [W-1:0]        den_q;
  logic [FRAC_W-1:0]   quo_q, quo_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                done_q, done_d;
  logic                ge;

  assign ge = rem_q >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {1'b0, num_i};
      quo_d = '0;
      cnt_d = 5'(FRAC_W);
    end else if (cnt_q != 5'd0) begin
      // subtract where it fits, then shift in the next zero bit
      rem_d  = (ge ? (rem_q - {1'b0, den_q}) : rem_q) << 1;
      quo_d  = {quo_q[FRAC_W-2:0], ge};
      cnt_d  = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hw/rtl/wks_dp.sv -----
// Datapath: sample memories, counts, weight sums, walk pointers and fractions.
`default_nettype none
module wks_dp import wks_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire req_t  req_i,
  input  wire cmd_t  cmd_i,
  output stat_t      stat_o,
  output res_t       res_o,
  output logic       done_o
);

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW = WEIGHT_W + CW;

  logic signed [SAMPLE_W-1:0] mem_sa [MAX_SAMPLES];
  logic [WEIGHT_W-1:0]        mem_wa [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] mem_sb [MAX_SAMPLES];
  logic [WEIGHT_W-1:0]        mem_wb [MAX_SAMPLES];

  logic signed [SAMPLE_W-1:0] sa_rd_q, sb_rd_q;
  logic [WEIGHT_W-1:0]        wa_rd_q, wb_rd_q;

  logic [CW-1:0]     cnt_a_q, cnt_b_q, j_q, i_q, jn, in_;
  logic [SW-1:0]     tot_a_q, tot_b_q, acc_a_q, acc_b_q;
  logic              ovf_q, done_q;
  logic [FRAC_W-1:0] best_q, quo_a, quo_b, gap;
  logic              done_a, done_b;
  logic              full_a, full_b;
  res_t              res_q;

  assign jn     = j_q + 1'b1;
  assign in_    = i_q + 1'b1;
  assign full_a = cnt_a_q >= CW'(MAX_SAMPLES);
  assign full_b = cnt_b_q >= CW'(MAX_SAMPLES);

  // memories: write on load, read walk positions every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !full_a) begin
      mem_sa[cnt_a_q[AW-1:0]] <= req_i.sample;
      mem_wa[cnt_a_q[AW-1:0]] <= req_i.weight;
    end
    if (cmd_i.load_b && !full_b) begin
      mem_sb[cnt_b_q[AW-1:0]] <= req_i.sample;
      mem_wb[cnt_b_q[AW-1:0]] <= req_i.weight;
    end
    sa_rd_q <= mem_sa[jn[AW-1:0]];
    wa_rd_q <= mem_wa[j_q[AW-1:0]];
    sb_rd_q <= mem_sb[i_q[AW-1:0]];
    wb_rd_q <= mem_wb[i_q[AW-1:0]];
  end

  wks_div #(.W(SW)) u_div_a (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go), .num_i(acc_a_q), .den_i(tot_a_q),
    .quo_o(quo_a), .done_o(done_a)
  );

  wks_div #(.W(SW)) u_div_b (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go), .num_i(acc_b_q), .den_i(tot_b_q),
    .quo_o(quo_b), .done_o(done_b)
  );

  assign gap = (quo_b > quo_a) ? (quo_b - quo_a) : (quo_a - quo_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      tot_a_q <= '0;
      tot_b_q <= '0;
      ovf_q   <= 1'b0;
      j_q     <= '0;
      i_q     <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
      best_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.load_a) begin
        if (full_a) ovf_q <= 1'b1;
        else begin
          cnt_a_q <= cnt_a_q + 1'b1;
          tot_a_q <= tot_a_q + SW'(req_i.weight);
        end
      end
      if (cmd_i.load_b) begin
        if (full_b) ovf_q <= 1'b1;
        else begin
          cnt_b_q <= cnt_b_q + 1'b1;
          tot_b_q <= tot_b_q + SW'(req_i.weight);
        end
      end
      if (cmd_i.init) begin
        j_q     <= '0;
        i_q     <= '0;
        acc_a_q <= '0;
        acc_b_q <= '0;
        best_q  <= '0;
      end
      if (cmd_i.adv_j) begin
        acc_a_q <= acc_a_q + SW'(wa_rd_q);
        j_q     <= jn;
      end
      if (cmd_i.step_i) begin
        if (gap > best_q) best_q <= gap;
        acc_b_q <= acc_b_q + SW'(wb_rd_q);
        i_q     <= in_;
      end
      if (cmd_i.emit) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        tot_a_q <= '0;
        tot_b_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.distance   <= stat_o.empty ? '0 : best_q;
      res_q.empty_set  <= stat_o.empty;
      res_q.overflowed <= ovf_q;
    end
  end

  assign stat_o.empty    = (cnt_a_q == '0) || (cnt_b_q == '0) ||
                           (tot_a_q == '0) || (tot_b_q == '0);
  assign stat_o.more_j   = (jn < cnt_a_q) && (sa_rd_q <= sb_rd_q);
  assign stat_o.div_done = done_a & done_b;
  assign stat_o.last_i   = (in_ == cnt_b_q);

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hw/rtl/wks_ctrl.sv -----
// Controller state machine sequencing loads and the merge walk.
`default_nettype none
module wks_ctrl import wks_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire logic [1:0] op_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op_i)
            OP_LOAD_A: cmd_o.load_a = 1'b1;
            OP_LOAD_B: cmd_o.load_b = 1'b1;
            OP_COMPUTE: begin
              if (stat_i.empty) cmd_o.emit = 1'b1;
              else begin
                cmd_o.init = 1'b1;
                state_d    = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (stat_i.more_j) begin
          cmd_o.adv_j = 1'b1;
          state_d     = S_RD;
        end else begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.step_i = 1'b1;
          state_d      = stat_i.last_i ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

// ----- hw/rtl/weighted_ks_distance.sv -----
// Weighted two-sample KS distance: top level joining controller and datapath.
//
// A request is taken at a clock edge with start high and busy low; req_i
// carries op, sample and weight. A load (first or second set) leaves busy
// low, so loads may be issued every cycle. Loads into a full set are dropped
// and noted for the next result.
// A compute request raises busy and walks both sets: each advance of the
// first-set pointer passes through the read and compare states, and each
// second-set sample waits for the two 17-step fraction dividers.
// When a set is empty or weightless the result comes the next cycle.
// The result sits on res_o for exactly one cycle with done_o high; the
// receiver cannot stall it. Afterwards both sets and the overflow mark are
// empty again.
// Reset clears counts, weight sums, overflow mark and the controller; the
// sample memories hold no defined value until loaded.
`default_nettype none
module weighted_ks_distance import wks_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output res_t      res_o,
  output logic      done_o
);

  cmd_t  cmd;
  stat_t stat;

  wks_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .op_i(req_i.op), .stat_i(stat), .cmd_o(cmd), .busy
  );

  wks_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .stat_o(stat), .res_o, .done_o
  );

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.distance <= 17'd65536) else $error("distance above 1.0");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.empty_set |-> res_o.distance == '0)
    else $error("empty result with nonzero distance");

  a_compute_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.op == OP_COMPUTE |=> busy || done_o)
    else $error("compute request ignored");

endmodule
`default_nettype wire
